/* design/efpf_pkg.sv */
package efpf_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int ROW_WORDS   = (SCREEN_WIDTH + 63) / 64;
  localparam int PLANE_WORDS = SCREEN_HEIGHT * ROW_WORDS;
  localparam int ADDR_W      = $clog2(PLANE_WORDS);
  localparam int WORD_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ROW_W       = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  localparam int POS_W       = 14;

  localparam int          LAST_BITS = SCREEN_WIDTH - (ROW_WORDS - 1) * 64;
  localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - LAST_BITS);

  localparam logic signed [POS_W-1:0] SCR_W_S  = POS_W'(SCREEN_WIDTH);
  localparam logic signed [POS_W-1:0] SCR_H_S  = POS_W'(SCREEN_HEIGHT);
  localparam logic signed [POS_W-1:0] HALF_W_S = POS_W'(SCREEN_WIDTH / 2);
  localparam logic signed [POS_W-1:0] HALF_H_S = POS_W'(SCREEN_HEIGHT / 2);

  localparam int XIN_W     = 10;
  localparam int YIN_W     = 9;
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = XIN_W + FRAC_W;
  localparam int DVS_W     = YIN_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int ACC_W     = 28;
  localparam int XI_W      = ACC_W - FRAC_W;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_FILL_RD,
    ST_FILL_LD
  } state_e;

  typedef struct packed {
    logic cap;
    logic clr_step;
    logic walk_init;
    logic walk_rd;
    logic walk_wr;
    logic fill_rd;
    logic fill_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic horiz;
    logic div_busy;
    logic walk_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

/* design/efpf_div.sv */
module efpf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [efpf_pkg::DVD_W-1:0]  dividend_i,
  input  logic [efpf_pkg::DVS_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [efpf_pkg::DVD_W-1:0]  quot_o
);
  import efpf_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d  = {quo_q[DVD_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

/* design/efpf_ctrl.sv */
module efpf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  efpf_pkg::sts_t      sts_i,
  output efpf_pkg::cmd_t      cmd_o
);
  import efpf_pkg::*;

  state_e state_q, state_d;
  mode_e  mode;

  assign mode = mode_e'(mode_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode)
            MODE_CLEAR: state_d = ST_CLEAR;
            MODE_EDGE:  state_d = ST_DIV;
            MODE_FILL:  state_d = ST_FILL_RD;
            MODE_NONE:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (sts_i.horiz) state_d = ST_IDLE;
        else if (!sts_i.div_busy) state_d = ST_WALK_RD;
      end
      ST_WALK_RD: state_d = ST_WALK_WR;
      ST_WALK_WR: begin
        state_d = sts_i.walk_last ? ST_IDLE : ST_WALK_RD;
      end
      ST_FILL_RD: state_d = ST_FILL_LD;
      ST_FILL_LD: begin
        if (sts_i.out_free) state_d = sts_i.fill_last ? ST_IDLE : ST_FILL_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR:   cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      ST_DIV:     cmd_o.walk_init = !sts_i.horiz && !sts_i.div_busy;
      ST_WALK_RD: cmd_o.walk_rd = 1'b1;
      ST_WALK_WR: cmd_o.walk_wr = 1'b1;
      ST_FILL_RD: cmd_o.fill_rd = 1'b1;
      ST_FILL_LD: cmd_o.fill_ld = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/efpf_dp.sv */
module efpf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  efpf_pkg::cmd_t                     cmd_i,
  output efpf_pkg::sts_t                     sts_o,
  input  logic signed [efpf_pkg::XIN_W-1:0]  x_start_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  y_start_i,
  input  logic signed [efpf_pkg::XIN_W-1:0]  x_end_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  y_end_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  row_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [3:0]                         word_index_o,
  output logic [63:0]                        fill_mask_o,
  output logic                               last_o
);
  import efpf_pkg::*;

  function automatic logic [63:0] prefix_par(input logic [63:0] w);
    logic [63:0] p;
    p = w;
    p = p ^ (p << 1);
    p = p ^ (p << 2);
    p = p ^ (p << 4);
    p = p ^ (p << 8);
    p = p ^ (p << 16);
    p = p ^ (p << 32);
    return p;
  endfunction

  // edge setup
  logic                    swap;
  logic signed [XIN_W-1:0] x_lo, x_hi;
  logic signed [YIN_W-1:0] y_lo, y_hi;
  logic signed [XIN_W:0]   dx;
  logic        [XIN_W:0]   dx_mag;
  logic signed [YIN_W:0]   dy_full;
  logic        [DVD_W-1:0] dividend;
  logic                    div_busy;
  logic        [DVD_W-1:0] quot;

  logic signed [XIN_W-1:0] x0_q;
  logic signed [YIN_W-1:0] y_q;
  logic        [YIN_W-1:0] rows_q;
  logic                    neg_q;
  logic                    horiz_q;

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] slope_q;
  logic        [ACC_W-1:0] slope_mag;

  // toggle address
  logic signed [XI_W-1:0]  xi_fl;
  logic signed [XI_W-1:0]  xi;
  logic signed [POS_W-1:0] t_col, t_row;
  logic                    t_on;
  logic        [ADDR_W-1:0] t_addr;
  logic        [63:0]      t_bit;

  // fill
  logic signed [POS_W-1:0] f_row;
  logic        [ROW_W-1:0] fill_row_q;
  logic                    fill_on_q;
  logic        [WORD_W-1:0] k_q;
  logic                    par_q;
  logic        [ADDR_W-1:0] f_addr;
  logic                    k_last;
  logic        [63:0]      m_raw, m_par, m_out;

  // clear sweep
  logic        [ADDR_W-1:0] clr_q;
  logic                     clr_last;

  // plane memory
  logic [63:0]       plane [PLANE_WORDS];
  logic [63:0]       rdata_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [63:0]       wdata;

  // result register
  logic        out_valid_q;
  logic [3:0]  word_index_q;
  logic [63:0] mask_q;
  logic        last_q;
  logic        out_free;

  always_comb begin
    swap    = !(y_start_i < y_end_i);
    x_lo    = swap ? x_end_i : x_start_i;
    y_lo    = swap ? y_end_i : y_start_i;
    x_hi    = swap ? x_start_i : x_end_i;
    y_hi    = swap ? y_start_i : y_end_i;
    dx      = {x_hi[XIN_W-1], x_hi} - {x_lo[XIN_W-1], x_lo};
    dx_mag  = dx[XIN_W] ? (~dx + 1'b1) : dx;
    dy_full = {y_hi[YIN_W-1], y_hi} - {y_lo[YIN_W-1], y_lo};
    dividend = {dx_mag[XIN_W-1:0], {FRAC_W{1'b0}}};
  end

  efpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cap),
    .dividend_i (dividend),
    .divisor_i  (dy_full[YIN_W-1:0]),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign slope_mag = {{(ACC_W-DVD_W){1'b0}}, quot};

  // x truncated toward zero, then screen position
  always_comb begin
    xi_fl = acc_q[ACC_W-1:FRAC_W];
    xi    = xi_fl + XI_W'(acc_q[ACC_W-1] && (acc_q[FRAC_W-1:0] != '0));
    t_col = {{(POS_W-XI_W){xi[XI_W-1]}}, xi} + HALF_W_S;
    t_row = {{(POS_W-YIN_W){y_q[YIN_W-1]}}, y_q} + HALF_H_S;
    t_on  = (t_col >= 0) && (t_col < SCR_W_S) && (t_row >= 0) && (t_row < SCR_H_S);
    t_addr = ADDR_W'(t_row[ROW_W-1:0] * ROW_WORDS)
           + ADDR_W'(t_col[COL_W-1:0] >> 6);
    t_bit  = 64'd1 << t_col[5:0];
  end

  always_comb begin
    f_row  = {{(POS_W-YIN_W){row_i[YIN_W-1]}}, row_i} + HALF_H_S;
    f_addr = ADDR_W'(fill_row_q * ROW_WORDS) + ADDR_W'(k_q);
    k_last = (k_q == WORD_W'(ROW_WORDS - 1));
    m_raw  = prefix_par(rdata_q);
    m_par  = par_q ? ~m_raw : m_raw;
    m_out  = '0;
    if (fill_on_q) m_out = k_last ? (m_par & LAST_MASK) : m_par;
  end

  assign clr_last = (clr_q == ADDR_W'(PLANE_WORDS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    we    = cmd_i.clr_step || (cmd_i.walk_wr && t_on);
    waddr = cmd_i.clr_step ? clr_q : t_addr;
    wdata = cmd_i.clr_step ? 64'd0 : (rdata_q ^ t_bit);
    re    = (cmd_i.walk_rd && t_on) || (cmd_i.fill_rd && fill_on_q);
    raddr = cmd_i.walk_rd ? t_addr : f_addr;
  end

  always_ff @(posedge clk_i) begin
    if (we) plane[waddr] <= wdata;
    if (re) rdata_q <= plane[raddr];
  end

  // edge walk and captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      x0_q       <= x_lo;
      y_q        <= y_lo;
      rows_q     <= dy_full[YIN_W-1:0];
      neg_q      <= dx[XIN_W];
      horiz_q    <= (dy_full == '0);
      fill_row_q <= f_row[ROW_W-1:0];
      fill_on_q  <= (f_row >= 0) && (f_row < SCR_H_S);
    end else if (cmd_i.walk_wr) begin
      y_q    <= y_q + 1'b1;
      rows_q <= rows_q - 1'b1;
    end
    if (cmd_i.walk_init) begin
      acc_q   <= {{(ACC_W-XIN_W-FRAC_W){x0_q[XIN_W-1]}}, x0_q, {FRAC_W{1'b0}}};
      slope_q <= neg_q ? -slope_mag : slope_mag;
    end else if (cmd_i.walk_wr) begin
      acc_q <= acc_q + slope_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      k_q         <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_last ? '0 : clr_q + 1'b1;
      if (cmd_i.cap) begin
        k_q   <= '0;
        par_q <= 1'b0;
      end else if (cmd_i.fill_ld) begin
        k_q   <= k_last ? '0 : k_q + 1'b1;
        par_q <= m_par[63];
      end
      if (cmd_i.fill_ld) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_ld) begin
      word_index_q <= 4'(k_q);
      mask_q       <= m_out;
      last_q       <= k_last;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = clr_last;
    sts_o.horiz     = horiz_q;
    sts_o.div_busy  = div_busy;
    sts_o.walk_last = (rows_q == YIN_W'(1));
    sts_o.fill_last = k_last;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign word_index_o = word_index_q;
  assign fill_mask_o  = mask_q;
  assign last_o       = last_q;

endmodule

/* design/edge_flag_polygon_fill_unit.sv */
// Edge-flag polygon fill over a 640x480 bit plane held in one 4800 x 64-bit
// memory, screen origin at the center. After reset the plane is swept to zero,
// during which no item is accepted; mode 0 runs the same sweep. Mode 1 (add
// edge) runs the serial Q10.16 slope division, one quotient bit per cycle,
// then a read-modify-write toggle per scan row on the plane memory; a
// horizontal edge returns to idle without the walk. Mode 2 (fill row) reads
// one word at a time and emits ten beats, leftmost word first with last on
// the tenth; a held output stalls the row walk.
module edge_flag_polygon_fill_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [efpf_pkg::XIN_W-1:0]  x_start_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  y_start_i,
  input  logic signed [efpf_pkg::XIN_W-1:0]  x_end_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  y_end_i,
  input  logic signed [efpf_pkg::YIN_W-1:0]  row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [3:0]                         word_index_o,
  output logic [63:0]                        fill_mask_o,
  output logic                               last_o
);
  import efpf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  efpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efpf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .row_i        (row_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .word_index_o (word_index_o),
    .fill_mask_o  (fill_mask_o),
    .last_o       (last_o)
  );

endmodule
